>>> rtl/skyline_rect_allocator_unit_assert.svh
// assertion macros for the skyline rectangle allocator
`ifndef SKYLINE_RECT_ALLOCATOR_UNIT_ASSERT_SVH
`define SKYLINE_RECT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define SRA_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sra check failed");

// next-cycle implication, checked on clk outside reset
`define SRA_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sra check failed");

`endif

>>> rtl/sra_pkg.sv
// shared constants and types for the skyline rectangle allocator
package sra_pkg;

  localparam int ATLAS_W_DEF = 128;
  localparam int ATLAS_H_DEF = 128;

  localparam int RECT_W = 8;
  localparam int POS_W  = 7;
  localparam int USED_W = 8;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              ok;
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;
    logic [USED_W-1:0] used_height;
  } rsp_t;

endpackage

>>> rtl/sra_if.sv
// request and response channel interfaces
interface sra_req_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [sra_pkg::RECT_W-1:0] rect_width;
  logic [sra_pkg::RECT_W-1:0] rect_height;

  modport source (output valid, output command, output rect_width, output rect_height,
                  input ready);
  modport sink (input valid, input command, input rect_width, input rect_height,
                output ready);
endinterface

interface sra_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [sra_pkg::POS_W-1:0]  x_pos;
  logic [sra_pkg::POS_W-1:0]  y_pos;
  logic [sra_pkg::USED_W-1:0] used_height;

  modport source (output valid, output ok, output x_pos, output y_pos, output used_height,
                  input ready);
  modport sink (input valid, input ok, input x_pos, input y_pos, input used_height,
                output ready);
endinterface

>>> rtl/sra_fill_mem.sv
// column fill memory, one write and one registered read port
module sra_fill_mem #(
  parameter int DEPTH = sra_pkg::ATLAS_W_DEF,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/sra_ctrl.sv
// allocation sequencer: window scan, placement write, clear sweep
`include "skyline_rect_allocator_unit_assert.svh"

module sra_ctrl #(
  parameter int ATLAS_W = sra_pkg::ATLAS_W_DEF,
  parameter int ATLAS_H = sra_pkg::ATLAS_H_DEF,
  localparam int AW = $clog2(ATLAS_W),
  localparam int FW = $clog2(ATLAS_H + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [sra_pkg::RECT_W-1:0] in_rect_width,
  input  logic [sra_pkg::RECT_W-1:0] in_rect_height,
  input  logic                       out_free,
  output logic                       rsp_load,
  output sra_pkg::rsp_t              rsp,
  output logic                       mem_rd_en,
  output logic [AW-1:0]              mem_rd_addr,
  input  logic [FW-1:0]              mem_rd_data,
  output logic                       mem_wr_en,
  output logic [AW-1:0]              mem_wr_addr,
  output logic [FW-1:0]              mem_wr_data
);

  localparam int SUMW = ((FW > sra_pkg::RECT_W) ? FW : sra_pkg::RECT_W) + 1;
  localparam int WCMP = ($clog2(ATLAS_W + 1) > sra_pkg::RECT_W) ?
                        $clog2(ATLAS_W + 1) : sra_pkg::RECT_W;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_PLACE, ST_RESP} state_t;

  state_t                    state;
  logic [AW-1:0]             sweep;
  logic                      clr_rsp;
  logic [AW-1:0]             w_r;
  logic [sra_pkg::RECT_W-1:0] h_r;
  logic [AW-1:0]             nxt_s, nxt_k;
  logic                      p_valid;
  logic [AW-1:0]             p_s, p_k;
  logic [FW-1:0]             peak, best;
  logic [AW-1:0]             bx, wk;
  logic                      found;
  logic [FW-1:0]             max_fill;
  logic                      ok_r;
  logic [sra_pkg::POS_W-1:0] x_r, y_r;

  logic                      accept, bad_size;
  logic [AW-1:0]             starts;
  logic                      abort, p_last;
  logic [FW-1:0]             peak_new;
  logic [AW-1:0]             pres_s, pres_k, adv_s, adv_k;
  logic                      pres_valid, scan_done;
  logic [SUMW-1:0]           sum;
  logic                      fit;
  logic [FW-1:0]             top_v;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign bad_size = (in_rect_width == '0) || (in_rect_height == '0) ||
                    (WCMP'(in_rect_width) >= WCMP'(ATLAS_W));
  assign starts   = AW'(ATLAS_W) - w_r;

  // window evaluation of the column read last cycle
  assign abort    = p_valid && (mem_rd_data >= best);
  assign p_last   = (p_k == w_r - AW'(1));
  assign peak_new = ((p_k == '0) || (mem_rd_data > peak)) ? mem_rd_data : peak;

  // an aborted window jumps straight to the next start
  assign pres_s     = abort ? p_s + AW'(1) : nxt_s;
  assign pres_k     = abort ? '0 : nxt_k;
  assign pres_valid = (state == ST_SCAN) && (pres_s < starts);
  assign adv_s      = (pres_k + AW'(1) == w_r) ? pres_s + AW'(1) : pres_s;
  assign adv_k      = (pres_k + AW'(1) == w_r) ? '0 : pres_k + AW'(1);
  assign scan_done  = (state == ST_SCAN) && !pres_valid && !p_valid;

  assign sum   = SUMW'(best) + SUMW'(h_r);
  assign fit   = found && (sum <= SUMW'(ATLAS_H));
  assign top_v = FW'(sum);

  assign mem_rd_en   = pres_valid;
  assign mem_rd_addr = pres_s + pres_k;

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = sweep;
    mem_wr_data = '0;
    case (state)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      ST_PLACE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = bx + wk;
        mem_wr_data = top_v;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  assign rsp_load        = (state == ST_RESP) && out_free;
  assign rsp.ok          = ok_r;
  assign rsp.x_pos       = x_r;
  assign rsp.y_pos       = y_r;
  assign rsp.used_height = sra_pkg::USED_W'(max_fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      sweep    <= '0;
      clr_rsp  <= 1'b0;
      p_valid  <= 1'b0;
      found    <= 1'b0;
      max_fill <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(ATLAS_W - 1)) begin
            sweep <= '0;
            state <= clr_rsp ? ST_RESP : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            x_r <= '0;
            y_r <= '0;
            if (in_command == sra_pkg::CMD_CLEAR) begin
              clr_rsp  <= 1'b1;
              max_fill <= '0;
              ok_r     <= 1'b1;
              sweep    <= '0;
              state    <= ST_CLEAR;
            end else if (bad_size) begin
              ok_r  <= 1'b0;
              state <= ST_RESP;
            end else begin
              w_r     <= AW'(in_rect_width);
              h_r     <= in_rect_height;
              nxt_s   <= '0;
              nxt_k   <= '0;
              p_valid <= 1'b0;
              best    <= FW'(ATLAS_H);
              found   <= 1'b0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          p_valid <= pres_valid;
          p_s     <= pres_s;
          p_k     <= pres_k;
          // once past the last start the scan position parks there
          if (pres_valid) begin
            nxt_s <= adv_s;
            nxt_k <= adv_k;
          end else begin
            nxt_s <= pres_s;
            nxt_k <= pres_k;
          end
          if (p_valid && !abort) begin
            peak <= peak_new;
            if (p_last) begin
              best  <= peak_new;
              bx    <= p_s;
              found <= 1'b1;
            end
          end
          if (scan_done) begin
            if (fit) begin
              wk    <= '0;
              state <= ST_PLACE;
            end else begin
              ok_r  <= 1'b0;
              state <= ST_RESP;
            end
          end
        end
        ST_PLACE: begin
          wk <= wk + AW'(1);
          if (wk == w_r - AW'(1)) begin
            ok_r  <= 1'b1;
            x_r   <= sra_pkg::POS_W'(bx);
            y_r   <= sra_pkg::POS_W'(best);
            if (top_v > max_fill) begin
              max_fill <= top_v;
            end
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            clr_rsp <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SRA_CHECK(a_rw_excl, mem_rd_en, !mem_wr_en)
  `SRA_CHECK(a_best_range, found, best < FW'(ATLAS_H))
  `SRA_CHECK(a_rd_window, p_valid && (state == ST_SCAN), p_k < w_r)
  `SRA_CHECK_NEXT(a_load_idle, rsp_load, state == ST_IDLE)

endmodule

>>> rtl/skyline_rect_allocator_unit.sv
// top level of the skyline rectangle allocator with response register
//
//   channel | dir | modport | carries
//   req     | in  | sink    | command, rect_width, rect_height
//   rsp     | out | source  | ok, x_pos, y_pos, used_height
//
// one request at a time; a new request is taken while the last response still waits
// allocate: the scan reads one column per cycle from the fill memory, at most
//   (ATLAS_W - rect_width) * rect_width reads, then rect_width columns are written
// clear: one memory entry zeroed per cycle
// after reset a clearing pass over all ATLAS_W entries runs before the first request is taken
// a stalled response holds in the output register; the sequencer waits for it to drain
module skyline_rect_allocator_unit #(
  parameter int ATLAS_W = sra_pkg::ATLAS_W_DEF,
  parameter int ATLAS_H = sra_pkg::ATLAS_H_DEF
) (
  input logic      clk,
  input logic      rst,
  sra_req_if.sink  req,
  sra_rsp_if.source rsp
);

  localparam int AW = $clog2(ATLAS_W);
  localparam int FW = $clog2(ATLAS_H + 1);

  // fill memory port signals
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [FW-1:0] mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [FW-1:0] mem_wr_data;

  // sequencer to output register
  logic          rsp_load;
  sra_pkg::rsp_t rsp_next;
  sra_pkg::rsp_t rsp_q;
  logic          rsp_valid;
  logic          out_free;

  // the output register can take a new response when empty or draining this cycle
  assign out_free = !rsp_valid || rsp.ready;

  sra_fill_mem #(
    .DEPTH (ATLAS_W),
    .WIDTH (FW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  sra_ctrl #(
    .ATLAS_W (ATLAS_W),
    .ATLAS_H (ATLAS_H)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .in_command     (req.command),
    .in_rect_width  (req.rect_width),
    .in_rect_height (req.rect_height),
    .out_free       (out_free),
    .rsp_load       (rsp_load),
    .rsp            (rsp_next),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data)
  );

  // response register, valid cleared by reset, payload loaded on demand
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_q.ok;
  assign rsp.x_pos       = rsp_q.x_pos;
  assign rsp.y_pos       = rsp_q.y_pos;
  assign rsp.used_height = rsp_q.used_height;

endmodule
